// ----- hw/rtl/sha256_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions of the SHA-256 hash engine.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef logic [31:0]      word_t;
  typedef logic [7:0][31:0] chain_t;

  // top level sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_PAD,
    ST_FINISH
  } state_e;

  // padding progress of the open message
  typedef enum logic [1:0] {
    PAD_NONE,
    PAD_MARK,
    PAD_FILL,
    PAD_LEN_LO
  } pad_e;

  // configuration register indexes
  localparam logic [2:0] CFG_ATTACK_ENABLE   = 3'd0;
  localparam logic [2:0] CFG_LENGTH_OVERRIDE = 3'd1;
  localparam logic [2:0] CFG_START_WORDS_01  = 3'd2;
  localparam logic [2:0] CFG_START_WORDS_23  = 3'd3;
  localparam logic [2:0] CFG_START_WORDS_45  = 3'd4;
  localparam logic [2:0] CFG_START_WORDS_67  = 3'd5;

  localparam logic [2:0] FULL_WORD_BYTES = 3'd4;
  localparam word_t      PAD_MARK_WORD   = 32'h8000_0000;

  // standard initial hash value, word zero in the lowest slot
  localparam chain_t SHA_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  typedef struct packed {
    logic load;   // load chaining value
    logic start;  // start compression of the window
  } core_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  typedef struct packed {
    logic push;   // shift in a message word
    logic step;   // shift in the next schedule word
  } sched_ctl_t;

  function automatic word_t rotr(word_t x, int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(word_t x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(word_t x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(word_t x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(word_t x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t ch(word_t e, word_t f, word_t g);
    ch = (e & f) ^ (~e & g);
  endfunction

  function automatic word_t maj(word_t a, word_t b, word_t c);
    maj = (a & b) ^ (a & c) ^ (b & c);
  endfunction

  // short last word: keep leading bytes, append the marker byte
  function automatic word_t tail_word(word_t w, logic [2:0] nb);
    case (nb)
      3'd0:    tail_word = PAD_MARK_WORD;
      3'd1:    tail_word = {w[31:24], 24'h80_0000};
      3'd2:    tail_word = {w[31:16], 16'h8000};
      3'd3:    tail_word = {w[31:8], 8'h80};
      default: tail_word = w;
    endcase
  endfunction

  function automatic word_t round_k(logic [5:0] t);
    case (t)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sha256_sched.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_sched
// Sixteen-word message schedule window as a shift line; tap zero is W[t].
// ----------------------------------------------------------------------------
module sha256_sched (
  input  wire logic                  clk_i,
  input  wire sha256_pkg::sched_ctl_t ctl_i,
  input  wire sha256_pkg::word_t     push_word_i,
  output sha256_pkg::word_t          w_o
);

  sha256_pkg::word_t win_q [16];
  sha256_pkg::word_t next_w;

  // W[t+16] from the current window
  assign next_w = sha256_pkg::small_sigma1(win_q[14]) + win_q[9]
                + sha256_pkg::small_sigma0(win_q[1]) + win_q[0];

  assign w_o = win_q[0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.push || ctl_i.step) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= ctl_i.push ? push_word_i : next_w;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/sha256_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_core
// Chaining value and one shared round unit run for 64 rounds per block.
// ----------------------------------------------------------------------------
module sha256_core (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire sha256_pkg::core_cmd_t  cmd_i,
  input  wire sha256_pkg::chain_t     load_value_i,
  input  wire sha256_pkg::word_t      w_i,
  output logic                        step_o,
  output sha256_pkg::core_stat_t      stat_o,
  output sha256_pkg::chain_t          chain_o
);

  sha256_pkg::chain_t chain_q, chain_d;
  sha256_pkg::chain_t work_q, work_d;
  logic [5:0]         round_q, round_d;
  logic               run_q, run_d;
  logic               add_q, add_d;
  sha256_pkg::word_t  t1, t2;

  assign t1 = work_q[7] + sha256_pkg::big_sigma1(work_q[4])
            + sha256_pkg::ch(work_q[4], work_q[5], work_q[6])
            + sha256_pkg::round_k(round_q) + w_i;
  assign t2 = sha256_pkg::big_sigma0(work_q[0])
            + sha256_pkg::maj(work_q[0], work_q[1], work_q[2]);

  always_comb begin
    chain_d = chain_q;
    work_d  = work_q;
    round_d = round_q;
    run_d   = run_q;
    add_d   = 1'b0;
    if (cmd_i.load) begin
      chain_d = load_value_i;
    end
    if (cmd_i.start) begin
      work_d  = chain_q;
      round_d = '0;
      run_d   = 1'b1;
    end else if (run_q) begin
      work_d[7] = work_q[6];
      work_d[6] = work_q[5];
      work_d[5] = work_q[4];
      work_d[4] = work_q[3] + t1;
      work_d[3] = work_q[2];
      work_d[2] = work_q[1];
      work_d[1] = work_q[0];
      work_d[0] = t1 + t2;
      round_d   = round_q + 6'd1;
      if (round_q == 6'd63) begin
        run_d = 1'b0;
        add_d = 1'b1;
      end
    end
    // feed-forward into the chaining value
    if (add_q) begin
      for (int i = 0; i < 8; i++) begin
        chain_d[i] = chain_q[i] + work_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= sha256_pkg::SHA_IV;
      round_q <= '0;
      run_q   <= 1'b0;
      add_q   <= 1'b0;
    end else begin
      chain_q <= chain_d;
      round_q <= round_d;
      run_q   <= run_d;
      add_q   <= add_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  assign step_o      = run_q;
  assign stat_o.busy = run_q || add_q;
  assign stat_o.done = add_q;
  assign chain_o     = chain_q;

endmodule
`default_nettype wire

// ----- hw/rtl/sha256_hash_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_hash_engine
// SHA-256 over a stream of big-endian words with hardware padding and an
// optional configured start value and length field.
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  s_axis    in         tdata msg_word, tuser word_bytes, tlast last_word
//  m_axis    out        tdata digest_01 .. digest_67, one beat per message
//  cfg       in         write enable, register index, 64-bit data
//
//  A non-last word is taken in the idle state; each 16th word adds a
//  compression (64 rounds in the shared round unit, then feed-forward).
//  The last word pushes up to 18 padding words, one per cycle outside a
//  compression, with one or two compressions, then loads the digest register.
//  Reset clears the sequencer and loads the standard initial value; no
//  clearing pass. A held digest does not stop the next message until its end.
// ----------------------------------------------------------------------------
module sha256_hash_engine (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [31:0]   s_axis_tdata,   // msg_word
  input  wire logic [2:0]    s_axis_tuser,   // word_bytes
  input  wire logic          s_axis_tlast,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [255:0]       m_axis_tdata,   // digest_01, 23, 45, 67
  input  wire logic          cfg_we_i,
  input  wire logic [2:0]    cfg_idx_i,
  input  wire logic [63:0]   cfg_data_i
);

  sha256_pkg::state_e state_q, state_d;
  sha256_pkg::pad_e   pad_q, pad_d;
  logic               open_q, open_d;
  logic [3:0]         slot_q, slot_d;
  logic [63:0]        bcnt_q, bcnt_d;
  logic [63:0]        len_q, len_d;
  logic               out_valid_q, out_valid_d;
  logic [255:0]       out_data_q;
  logic               out_load;

  logic               attack_q;
  logic [63:0]        length_ovr_q;
  logic [3:0][63:0]   start_q;

  sha256_pkg::core_cmd_t  core_cmd;
  sha256_pkg::core_stat_t core_stat;
  sha256_pkg::sched_ctl_t sched_ctl;
  sha256_pkg::chain_t     start_value;
  sha256_pkg::chain_t     chain;
  sha256_pkg::word_t      push_word;
  sha256_pkg::word_t      sched_w;
  logic                   core_step;
  logic                   accept;
  logic [2:0]             nb;
  logic [63:0]            bcnt_base;

  assign s_axis_tready = (state_q == sha256_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign nb = (s_axis_tuser > sha256_pkg::FULL_WORD_BYTES) ?
              sha256_pkg::FULL_WORD_BYTES : s_axis_tuser;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      start_value[2*i]   = start_q[i][63:32];
      start_value[2*i+1] = start_q[i][31:0];
    end
  end

  // sequencer
  always_comb begin
    state_d        = state_q;
    pad_d          = pad_q;
    open_d         = open_q;
    slot_d         = slot_q;
    bcnt_d         = bcnt_q;
    len_d          = len_q;
    out_load       = 1'b0;
    core_cmd.load  = 1'b0;
    core_cmd.start = 1'b0;
    sched_ctl.push = 1'b0;
    sched_ctl.step = core_step;
    push_word      = s_axis_tdata;
    bcnt_base      = open_q ? bcnt_q : 64'd0;

    case (state_q)
      sha256_pkg::ST_IDLE: begin
        if (accept) begin
          core_cmd.load  = !open_q;
          sched_ctl.push = 1'b1;
          slot_d         = slot_q + 4'd1;
          if (!s_axis_tlast) begin
            open_d = 1'b1;
            bcnt_d = bcnt_base + 64'd32;
          end else begin
            open_d = 1'b0;
            bcnt_d = bcnt_base + {58'd0, nb, 3'b000};
            len_d  = attack_q ? length_ovr_q : bcnt_d;
            if (nb == sha256_pkg::FULL_WORD_BYTES) begin
              pad_d = sha256_pkg::PAD_MARK;
            end else begin
              push_word = sha256_pkg::tail_word(s_axis_tdata, nb);
              pad_d     = sha256_pkg::PAD_FILL;
            end
            state_d = sha256_pkg::ST_PAD;
          end
          if (slot_q == 4'd15) begin
            core_cmd.start = 1'b1;
            state_d        = sha256_pkg::ST_ROUND;
          end
        end
      end

      sha256_pkg::ST_ROUND: begin
        if (core_stat.done) begin
          case (pad_q)
            sha256_pkg::PAD_NONE:   state_d = sha256_pkg::ST_IDLE;
            sha256_pkg::PAD_LEN_LO: state_d = sha256_pkg::ST_FINISH;
            default:                state_d = sha256_pkg::ST_PAD;
          endcase
        end
      end

      sha256_pkg::ST_PAD: begin
        sched_ctl.push = 1'b1;
        slot_d         = slot_q + 4'd1;
        case (pad_q)
          sha256_pkg::PAD_MARK: begin
            push_word = sha256_pkg::PAD_MARK_WORD;
            pad_d     = sha256_pkg::PAD_FILL;
          end
          sha256_pkg::PAD_FILL: begin
            if (slot_q == 4'd14) begin
              push_word = len_q[63:32];
              pad_d     = sha256_pkg::PAD_LEN_LO;
            end else begin
              push_word = '0;
            end
          end
          default: begin
            push_word = len_q[31:0];
          end
        endcase
        if (slot_q == 4'd15) begin
          core_cmd.start = 1'b1;
          state_d        = sha256_pkg::ST_ROUND;
        end
      end

      sha256_pkg::ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          pad_d    = sha256_pkg::PAD_NONE;
          state_d  = sha256_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = sha256_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha256_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_q       <= sha256_pkg::PAD_NONE;
      open_q      <= 1'b0;
      slot_q      <= '0;
      bcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pad_q       <= pad_d;
      open_q      <= open_d;
      slot_q      <= slot_d;
      bcnt_q      <= bcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    if (out_load) begin
      for (int i = 0; i < 4; i++) begin
        out_data_q[64*i +: 64] <= {chain[2*i], chain[2*i+1]};
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q     <= 1'b0;
      length_ovr_q <= '0;
      start_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sha256_pkg::CFG_ATTACK_ENABLE:   attack_q     <= cfg_data_i[0];
        sha256_pkg::CFG_LENGTH_OVERRIDE: length_ovr_q <= cfg_data_i;
        sha256_pkg::CFG_START_WORDS_01:  start_q[0]   <= cfg_data_i;
        sha256_pkg::CFG_START_WORDS_23:  start_q[1]   <= cfg_data_i;
        sha256_pkg::CFG_START_WORDS_45:  start_q[2]   <= cfg_data_i;
        sha256_pkg::CFG_START_WORDS_67:  start_q[3]   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sha256_sched u_sched (
    .clk_i       (clk_i),
    .ctl_i       (sched_ctl),
    .push_word_i (push_word),
    .w_o         (sched_w)
  );

  sha256_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (core_cmd),
    .load_value_i (attack_q ? start_value : sha256_pkg::SHA_IV),
    .w_i          (sched_w),
    .step_o       (core_step),
    .stat_o       (core_stat),
    .chain_o      (chain)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // no input while the round unit is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !core_stat.busy)
    else $error("input ready during compression");

  // compression only ends while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_stat.done |-> state_q == sha256_pkg::ST_ROUND)
    else $error("compression done outside round state");

  // a new message always starts on a block boundary
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha256_pkg::ST_IDLE && !open_q) |-> slot_q == 4'd0)
    else $error("word slot not at block start between messages");

  // padding is never left pending while waiting for input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> pad_q == sha256_pkg::PAD_NONE)
    else $error("padding pending while accepting input");

  // after the digest register loads, the digest is presented and the sequencer idles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid && state_q == sha256_pkg::ST_IDLE)
    else $error("digest not presented after finish");

endmodule
`default_nettype wire
